// ===== rtl/dtd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

   // Depth of the command queue between the classifier and the expander.
   localparam int unsigned QUEUE_DEPTH = 4;

   // What the expander has to produce for one classified byte.
   typedef enum logic [1:0] {
      CMD_CHAR,     // one character, carried in the code field
      CMD_DIGRAM,   // two characters looked up from the code
      CMD_UNKNOWN,  // unknown escape text, selector in the code field
      CMD_MARK      // empty end marker, with or without the escape error
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   code;
      logic         last;
      logic         err;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/dtd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [7:0]      code_byte,
   input  wire logic            string_last,
   input  wire logic            queue_full,
   output logic                 push,
   output dtd_pkg::cmd_type     push_cmd
);

   localparam logic [7:0] CodeNull    = 8'h00;
   localparam logic [7:0] CodeSkipA   = 8'h03;
   localparam logic [7:0] CodeSkipB   = 8'h04;
   localparam logic [7:0] CodeNewA    = 8'h0C;
   localparam logic [7:0] CodeNewB    = 8'h0D;
   localparam logic [7:0] CodeEscape  = 8'h1B;
   localparam logic [7:0] CodePeriod  = 8'h1F;
   localparam logic [7:0] SelUeLow    = 8'h02;
   localparam logic [7:0] SelAeLow    = 8'h05;
   localparam logic [7:0] SelAringUp  = 8'h0F;
   localparam logic [7:0] SelOeLow    = 8'h15;
   localparam logic [7:0] SelUeUp     = 8'h1B;
   localparam logic [7:0] SelSharpS   = 8'h62;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharPeriod  = 8'h2E;

   logic escape_ff;
   logic escape_in;
   logic accept;

   // A byte is taken whenever the queue has room for its command.
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Classify the accepted byte into one command, or none for silent bytes.
   always_comb begin
      escape_in     = escape_ff;
      push          = 1'b0;
      push_cmd.kind = dtd_pkg::CMD_CHAR;
      push_cmd.code = code_byte;
      push_cmd.last = string_last;
      push_cmd.err  = 1'b0;
      if (accept) begin
         if (escape_ff) begin
            escape_in = 1'b0;
            push      = 1'b1;
            case (code_byte)
               SelUeLow:   push_cmd.code = 8'd252;
               SelAeLow:   push_cmd.code = 8'd228;
               SelAringUp: push_cmd.code = 8'd197;
               SelOeLow:   push_cmd.code = 8'd246;
               SelUeUp:    push_cmd.code = 8'd220;
               SelSharpS:  push_cmd.code = 8'd223;
               default:    push_cmd.kind = dtd_pkg::CMD_UNKNOWN;
            endcase
         end else if (code_byte[7]) begin
            push          = 1'b1;
            push_cmd.kind = dtd_pkg::CMD_DIGRAM;
         end else begin
            case (code_byte)
               CodeNull, CodeSkipA, CodeSkipB: begin
                  push          = string_last;
                  push_cmd.kind = dtd_pkg::CMD_MARK;
               end
               CodeNewA, CodeNewB: begin
                  push          = 1'b1;
                  push_cmd.code = CharNewline;
               end
               CodePeriod: begin
                  push          = 1'b1;
                  push_cmd.code = CharPeriod;
               end
               CodeEscape: begin
                  // An escape on the last byte closes the string with an error.
                  push          = string_last;
                  push_cmd.kind = dtd_pkg::CMD_MARK;
                  push_cmd.err  = 1'b1;
                  escape_in     = !string_last;
               end
               default: begin
                  push = 1'b1;
               end
            endcase
         end
      end
   end

   // Escape flag register.
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dtd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtd_queue #(
   parameter int unsigned DEPTH = dtd_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dtd_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output dtd_pkg::cmd_type      head_cmd
);

   localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0]   PtrTop    = PtrW'(DEPTH - 1);
   localparam logic [CountW-1:0] CountFull = CountW'(DEPTH);

   dtd_pkg::cmd_type entries_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_in;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CountFull);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrTop) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrTop) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dtd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire dtd_pkg::cmd_type head_cmd,
   output logic                  pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [7:0]            out_char,
   output logic                  char_valid,
   output logic                  run_last,
   output logic                  string_end,
   output logic                  escape_error
);

   localparam logic [8*16-1:0]  FirstChars  = " etainosrlhcdupm";
   localparam logic [8*128-1:0] SecondChars = {
      "tasio wb", " rnsdalm", "h ieoras", "nrtlc sy",
      "nstcloer", " dtgesio", "nr ufmsw", " tep.ica",
      "e oiadur", " laeiyod", "eia otru", "etoakhlr",
      " eiu,.oa", "nsrctlai", "leoiratp", "eaoip bm"};
   localparam logic [8*16-1:0]  UnknownHead = "---Unknown char:";
   localparam logic [7:0]       CharDash    = 8'h2D;
   localparam logic [4:0]       HeadLen     = 5'd16;

   function automatic logic [7:0] hex_digit(input logic [3:0] d);
      hex_digit = (d < 4'd10) ? (8'h30 + {4'b0000, d}) : (8'h37 + {4'b0000, d});
   endfunction

   dtd_pkg::cmd_type cmd_ff;
   dtd_pkg::cmd_type cmd_in;
   logic             active_ff;
   logic             active_in;
   logic [4:0]       idx_ff;
   logic [4:0]       idx_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic [7:0]       char_ff;
   logic             cvalid_ff;
   logic             run_last_ff;
   logic             str_end_ff;
   logic             err_ff;

   logic [4:0]       final_idx;
   logic [7:0]       cur_char;
   logic             cur_final;
   logic             emit;
   logic [6:0]       second_sel;
   logic [3:0]       first_sel;
   logic [1:0]       hex_len;

   assign first_sel  = cmd_ff.code[6:3];
   assign second_sel = cmd_ff.code[6:0];
   assign hex_len    = (cmd_ff.code[7:4] != 4'h0) ? 2'd2 : 2'd1;

   // Character for the current position of the active command.
   always_comb begin
      final_idx = 5'd0;
      cur_char  = cmd_ff.code;
      case (cmd_ff.kind)
         dtd_pkg::CMD_CHAR: begin
            final_idx = 5'd0;
            cur_char  = cmd_ff.code;
         end
         dtd_pkg::CMD_DIGRAM: begin
            final_idx = 5'd1;
            cur_char  = idx_ff[0] ? SecondChars[{~second_sel, 3'b000} +: 8]
                                  : FirstChars[{~first_sel, 3'b000} +: 8];
         end
         dtd_pkg::CMD_UNKNOWN: begin
            // Head text, one or two hex digits, then three dashes.
            final_idx = HeadLen + {3'b000, hex_len} + 5'd2;
            if (idx_ff < HeadLen) begin
               cur_char = UnknownHead[{~idx_ff[3:0], 3'b000} +: 8];
            end else if (idx_ff < HeadLen + {3'b000, hex_len}) begin
               cur_char = (hex_len == 2'd2 && idx_ff == HeadLen)
                          ? hex_digit(cmd_ff.code[7:4]) : hex_digit(cmd_ff.code[3:0]);
            end else begin
               cur_char = CharDash;
            end
         end
         dtd_pkg::CMD_MARK: begin
            final_idx = 5'd0;
            cur_char  = 8'h00;
         end
         default: begin
            final_idx = 5'd0;
            cur_char  = 8'h00;
         end
      endcase
   end

   assign cur_final = (idx_ff == final_idx);
   assign emit      = active_ff && (!out_valid_ff || out_ready);
   assign pop       = head_valid && (!active_ff || (emit && cur_final));

   // Step through the active command and take the next one from the queue.
   always_comb begin
      cmd_in       = cmd_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (emit) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + 5'd1;
         if (cur_final) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         cmd_in    = head_cmd;
         active_in = 1'b1;
         idx_in    = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Command and output payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         char_ff     <= cur_char;
         cvalid_ff   <= (cmd_ff.kind != dtd_pkg::CMD_MARK);
         run_last_ff <= cur_final;
         str_end_ff  <= cur_final && cmd_ff.last;
         err_ff      <= (cmd_ff.kind == dtd_pkg::CMD_MARK) && cmd_ff.err;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_char     = char_ff;
   assign char_valid   = cvalid_ff;
   assign run_last     = run_last_ff;
   assign string_end   = str_end_ff;
   assign escape_error = err_ff;

   // The end of a string always closes the run of its byte.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && str_end_ff |-> run_last_ff)
      else $error("string end without run end");

   // An escape error is carried only by an empty end marker.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && err_ff |-> !cvalid_ff && str_end_ff)
      else $error("escape error on a character result");

   // The position never runs past the longest unknown-escape text.
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff <= 5'd20)
      else $error("position beyond last character");

   // A new command is taken only once the current one has emitted its last character.
   assert property (@(posedge clock) disable iff (reset)
      pop && active_ff |-> emit && cur_final)
      else $error("command replaced before completion");

   // A stalled result holds its character until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(char_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/digram_text_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Contents
// req       in         req_tvalid/req_tready   code byte, last byte of the string
// rsp       out        rsp_tvalid/rsp_tready   character, flags, run and string end
//
// One character leaves per cycle while rsp_tready is high and the queue has commands.
// A byte yields 1 character if plain, 2 for a digram, 20 or 21 for an unknown escape.
// Silent bytes are accepted by the front and queue no command. The expander's
// position counter sets the rate; the command queue lets the front accept while it works.
// Reset is synchronous and active high and clears the escape flag and the command queue.
// A stalled result holds in the output register while the queue fills behind it.

module digram_text_decoder #(
   parameter int unsigned QUEUE_DEPTH = dtd_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] code_byte
   input  wire logic        req_tlast,   // string_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_char, [8] run_last, [15:9] zero
   output logic [1:0]       rsp_tuser,   // [0] char_valid, [1] escape_error
   output logic             rsp_tlast    // string_end
);

   logic             push;
   dtd_pkg::cmd_type push_cmd;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   dtd_pkg::cmd_type head_cmd;
   logic [7:0]       out_char;
   logic             run_last;

   dtd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .code_byte   (req_tdata),
      .string_last (req_tlast),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   dtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   dtd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_char     (out_char),
      .char_valid   (rsp_tuser[0]),
      .run_last     (run_last),
      .string_end   (rsp_tlast),
      .escape_error (rsp_tuser[1])
   );

   // Pack the result payload.
   assign rsp_tdata = {7'b0000000, run_last, out_char};

endmodule

`default_nettype wire
